// File: rtl/pds_pkg.sv
// package for the periodic task dispatcher: sizes, codes, payload types
// and period reset values; no dependencies
`default_nettype none

package pds_pkg;

    localparam int TASK_COUNT     = 8;
    localparam int TIMER_BITS     = 16;
    localparam int REG_COUNT      = 8;
    localparam int PERIOD_BITS    = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int TASK_IDX_BITS  = 3;
    localparam int MASK_BITS      = 8;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_ARM  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                      operation;
        logic [TASK_IDX_BITS-1:0] task_index;
    } t_in_item;

    typedef struct packed {
        logic                     dispatched;
        logic [TASK_IDX_BITS-1:0] dispatched_task;
        logic [MASK_BITS-1:0]     pending_mask;
    } t_out_item;

    typedef logic [TASK_COUNT-1:0][PERIOD_BITS-1:0] t_period_arr;

    typedef logic [REG_COUNT-1:0][PERIOD_BITS-1:0] t_period_rst;

    localparam t_period_rst PERIOD_RESET = {
        16'd30, 16'd50, 16'd20, 16'd3, 16'd5, 16'd90, 16'd10, 16'd20
    };

    // handshake between the input stage and the scheduler core
    typedef struct packed {
        logic     step;
        t_in_item item;
    } t_core_ctl;

endpackage

`default_nettype wire

// File: rtl/pds_periods.sv
// reload period registers written through the configuration port
// depends on pds_pkg
`default_nettype none

module pds_periods
    import pds_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [PERIOD_BITS-1:0]    i_cfg_data,
    output t_period_arr                    o_period
);

    t_period_arr r_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_period[i] <= (i < REG_COUNT) ? PERIOD_RESET[i] : '0;
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < TASK_COUNT; i++) begin
                // tasks without a register keep period zero
                if (i < REG_COUNT && 32'(i_cfg_index) == i) begin
                    r_period[i] <= i_cfg_data;
                end
            end
        end
    end

    assign o_period = r_period;

endmodule

`default_nettype wire

// File: rtl/pds_core.sv
// scheduler core: countdown timers, pending bits, lowest-index pick
// depends on pds_pkg
`default_nettype none

module pds_core
    import pds_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_core_ctl i_ctl,
    input  t_period_arr i_period,
    output t_out_item o_result
);

    logic [TASK_COUNT-1:0][TIMER_BITS-1:0] r_timer;
    logic [TASK_COUNT-1:0][TIMER_BITS-1:0] n_timer;
    logic [TASK_COUNT-1:0]                 r_pending;
    logic [TASK_COUNT-1:0]                 n_pending;
    logic                                  found;
    int                                    which;

    always_comb begin
        n_timer   = r_timer;
        n_pending = r_pending;
        found     = 1'b0;
        which     = 0;
        unique case (i_ctl.item.operation)
            OP_ARM: begin
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (32'(i_ctl.item.task_index) == i) begin
                        n_pending[i] = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (r_timer[i] != '0) begin
                        n_timer[i] = r_timer[i] - 1'b1;
                        if (r_timer[i] == TIMER_BITS'(1)) begin
                            n_pending[i] = 1'b1;
                        end
                    end
                end
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (!found && n_pending[i]) begin
                        found        = 1'b1;
                        which        = i;
                        n_pending[i] = 1'b0;
                        n_timer[i]   = TIMER_BITS'(i_period[i]);
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.dispatched      = found;
        o_result.dispatched_task = TASK_IDX_BITS'(which);
        o_result.pending_mask    = MASK_BITS'(n_pending);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer   <= '0;
            r_pending <= '0;
        end else if (i_ctl.step) begin
            r_timer   <= n_timer;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

// File: rtl/periodic_task_dispatcher.sv
// top level of the periodic task dispatcher: input register, scheduler
// core, result register; depends on pds_pkg, pds_periods and pds_core
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall       i_data  (t_in_item)
//   result    out        o_valid / i_stall       o_data  (t_out_item)
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one request per cycle sustained while the result side does not stall; each
// request gives one result, through the input register, then the result register
// the timer and pending update happens as a request moves into the result
// register, so the core loop through the timer and pending registers sets the rate
// synchronous active-low reset clears timers, pending bits and both valids,
// and loads the default periods
// a stalled result holds; the input register still takes a request while
// the result register is free or draining
`default_nettype none

module periodic_task_dispatcher
    import pds_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  t_in_item                       i_data,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output t_out_item                      o_data,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [PERIOD_BITS-1:0]    i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in_data;
    logic        r_out_valid;
    t_out_item   r_out_data;
    logic        out_load;
    logic        in_load;
    t_core_ctl   core_ctl;
    t_out_item   core_result;
    t_period_arr period;

    assign out_load    = !r_out_valid || !i_stall;
    assign o_stall     = r_in_valid && !out_load;
    assign in_load     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign core_ctl.step = r_in_valid && out_load;
    assign core_ctl.item = r_in_data;

    pds_periods u_periods (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_period    (period)
    );

    pds_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (core_ctl),
        .i_period (period),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_data <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_ctl.step) begin
            r_out_data <= core_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // the dispatched task is never left pending in the same result
    a_disp_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.dispatched
            |-> !r_out_data.pending_mask[r_out_data.dispatched_task])
        else $error("dispatched task still pending");

    // no dispatch reports task zero
    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.dispatched |-> r_out_data.dispatched_task == '0)
        else $error("index reported without dispatch");

    // an arm request never dispatches
    a_arm_no_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_ctl.step && r_in_data.operation == OP_ARM |=> !r_out_data.dispatched)
        else $error("arm request dispatched a task");

    // input stall only while a request waits behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without cause");

endmodule

`default_nettype wire

// File: dv/periodic_task_dispatcher_test.sv
// self-checking testbench for periodic_task_dispatcher: drives tick and arm requests,
// reprograms the reload periods between phases and scores every result against a predictor
// depends on pds_pkg and the periodic_task_dispatcher rtl
`default_nettype none

module periodic_task_dispatcher_test;
    import pds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      in_valid    = 1'b0;
    t_in_item                  in_data     = '0;
    logic                      rx_stall    = 1'b0;
    logic                      cfg_valid   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [PERIOD_BITS-1:0]    cfg_data    = '0;
    logic                      dut_stall;
    logic                      out_valid;
    t_out_item                 out_data;
    logic                      cfg_ready;

    periodic_task_dispatcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .o_stall     (dut_stall),
        .i_data      (in_data),
        .o_valid     (out_valid),
        .i_stall     (rx_stall),
        .o_data      (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // scheduler state as the testbench sees it
    logic [TIMER_BITS-1:0]  sched_timer  [TASK_COUNT];
    logic [PERIOD_BITS-1:0] sched_period [TASK_COUNT];
    logic [MASK_BITS-1:0]   sched_pending;

    t_in_item   pending_requests [$];
    t_out_item  expected_results [$];
    t_idle_mode idle_mode = IDLE_RX_HEAVY;

    int n_requests   = 0;
    int n_results    = 0;
    int n_dispatched = 0;
    int n_cfg_writes = 0;
    int n_errors     = 0;
    int hold_count   = 0;
    int quiet_cycles = 0;

    function automatic t_out_item dispatch_step(t_in_item it);
        t_out_item res;
        res = '0;
        if (it.operation == OP_ARM) begin
            sched_pending[it.task_index] = 1'b1;
        end else begin
            for (int i = 0; i < TASK_COUNT; i++) begin
                if (sched_timer[i] != '0) begin
                    sched_timer[i] = sched_timer[i] - 1'b1;
                    if (sched_timer[i] == '0) sched_pending[i] = 1'b1;
                end
            end
            // lowest-numbered pending task wins
            for (int i = 0; i < TASK_COUNT; i++) begin
                if (!res.dispatched && sched_pending[i]) begin
                    res.dispatched      = 1'b1;
                    res.dispatched_task = TASK_IDX_BITS'(i);
                    sched_pending[i]    = 1'b0;
                    sched_timer[i]      = sched_period[i];
                end
            end
        end
        res.pending_mask = sched_pending;
        return res;
    endfunction

    function automatic t_in_item req(t_op op, int idx);
        t_in_item it;
        it.operation  = op;
        it.task_index = TASK_IDX_BITS'(idx);
        return it;
    endfunction

    function automatic t_in_item pick_request(int arm_pct);
        t_in_item it;
        it.operation  = ($urandom_range(0, 99) < arm_pct) ? OP_ARM : OP_TICK;
        it.task_index = TASK_IDX_BITS'($urandom_range(0, 7));
        return it;
    endfunction

    // mostly short periods so timers expire often, with the extremes mixed in
    function automatic logic [PERIOD_BITS-1:0] pick_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 14) return '1;
        if (r < 20) return PERIOD_BITS'($urandom);
        return PERIOD_BITS'($urandom_range(1, 12));
    endfunction

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !dut_stall) begin
                expected_results.push_back(dispatch_step(in_data));
                n_requests++;
            end
            if (!in_valid || !dut_stall) begin
                if (pending_requests.size() != 0 &&
                    !coin(idle_mode == IDLE_RX_HEAVY ? 6 :
                          idle_mode == IDLE_TX_HEAVY ? 58 : 0)) begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin : rx_side
        t_out_item want;
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
        end else begin
            if (out_valid && !rx_stall) begin
                n_results++;
                if (out_data.dispatched) n_dispatched++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.dispatched !== want.dispatched) begin
                        $display("%0t: dispatched expected %b actual %b",
                                 $time, want.dispatched, out_data.dispatched);
                        n_errors++;
                    end
                    if (out_data.dispatched_task !== want.dispatched_task) begin
                        $display("%0t: dispatched_task expected %0d actual %0d",
                                 $time, want.dispatched_task, out_data.dispatched_task);
                        n_errors++;
                    end
                    if (out_data.pending_mask !== want.pending_mask) begin
                        $display("%0t: pending_mask expected %h actual %h",
                                 $time, want.pending_mask, out_data.pending_mask);
                        n_errors++;
                    end
                end
            end
            // long hold-off at the start of the no-idle phase to back up the pipe
            if (idle_mode == IDLE_NONE && hold_count < HOLD_CYCLES) begin
                hold_count <= hold_count + 1;
                rx_stall   <= 1'b1;
            end else begin
                rx_stall <= coin(idle_mode == IDLE_RX_HEAVY ? 58 :
                                 idle_mode == IDLE_TX_HEAVY ? 6 : 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !dut_stall) || (out_valid && !rx_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("periodic_task_dispatcher_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // caller lowers cfg_valid after the last write of a batch
    task automatic write_period(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [PERIOD_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx < REG_COUNT) sched_period[idx[TASK_IDX_BITS-1:0]] = val;
        n_cfg_writes++;
    endtask

    task automatic program_random_periods();
        for (int i = 0; i < REG_COUNT; i++) write_period(CFG_INDEX_BITS'(i), pick_period());
        write_period(CFG_INDEX_BITS'($urandom_range(REG_COUNT, 255)), PERIOD_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(t_idle_mode mode);
        idle_mode = mode;
        program_random_periods();
        for (int i = 0; i < 220; i++) pending_requests.push_back(pick_request(25));
        wait_drain();
        for (int i = 0; i < 220; i++) pending_requests.push_back(pick_request(40));
        wait_drain();
    endtask

    initial begin
        sched_period[0] = 16'd20;
        sched_period[1] = 16'd10;
        sched_period[2] = 16'd90;
        sched_period[3] = 16'd5;
        sched_period[4] = 16'd3;
        sched_period[5] = 16'd20;
        sched_period[6] = 16'd50;
        sched_period[7] = 16'd30;
        for (int i = 0; i < TASK_COUNT; i++) sched_timer[i] = '0;
        sched_pending = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default periods: empty tick, arm every task plus a repeat, then dispatch in order
        pending_requests.push_back(req(OP_TICK, 7));
        for (int i = 0; i < TASK_COUNT; i++) pending_requests.push_back(req(OP_ARM, i));
        pending_requests.push_back(req(OP_ARM, 3));
        repeat (6) pending_requests.push_back(req(OP_TICK, 0));
        wait_drain();

        // one-shot, every-tick and longest periods, plus writes to missing registers
        write_period(CFG_INDEX_BITS'(0), 16'd0);
        write_period(CFG_INDEX_BITS'(1), 16'd1);
        write_period(CFG_INDEX_BITS'(2), 16'hFFFF);
        write_period(CFG_INDEX_BITS'(7), 16'hFFFF);
        write_period(CFG_INDEX_BITS'(8), 16'h1234);
        write_period(CFG_INDEX_BITS'(255), 16'hFFFF);
        cfg_valid <= 1'b0;
        pending_requests.push_back(req(OP_ARM, 0));
        pending_requests.push_back(req(OP_TICK, 5));
        pending_requests.push_back(req(OP_TICK, 0));
        pending_requests.push_back(req(OP_ARM, 1));
        pending_requests.push_back(req(OP_TICK, 2));
        pending_requests.push_back(req(OP_TICK, 0));
        pending_requests.push_back(req(OP_ARM, 7));
        pending_requests.push_back(req(OP_TICK, 7));
        wait_drain();

        run_random_phase(IDLE_RX_HEAVY);
        run_random_phase(IDLE_TX_HEAVY);
        run_random_phase(IDLE_NONE);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            n_errors++;
        end
        $display("covered %0d requests and %0d results (%0d dispatches), %0d period writes",
                 n_requests, n_results, n_dispatched, n_cfg_writes);
        $display("across both idling mixes, a long result hold-off and back-to-back traffic");
        if (n_errors == 0) begin
            $display("periodic_task_dispatcher_test: PASS");
        end else begin
            $display("periodic_task_dispatcher_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
